// ----- sv/ocs_pkg.sv -----
// Package for the orbit camera swing block: fixed-point constants, types,
// the CORDIC arctangent table and small helper functions.
// No dependencies.
package ocs_pkg;

   // Coordinate and angle formats
   localparam int COORD_FRAC_BITS  = 16;
   localparam int ANGLE_STEPS      = 64;
   localparam int ANGLE_FULL       = 360 * ANGLE_STEPS;
   localparam int ANGLE_QUARTER    = 90 * ANGLE_STEPS;
   localparam int MIN_RADIUS       = ((1 << COORD_FRAC_BITS) + 5) / 10;
   localparam int ONE_DEG_Q30      = 18740330;
   localparam int CORDIC_GAIN_Q30  = 652032874;
   localparam int CORDIC_ITER_DEF  = 24;
   localparam int CAM_RESET        = 2 << COORD_FRAC_BITS;
   localparam int HORIZ_RESET      = 315 * ANGLE_STEPS;
   localparam int VERT_RESET       = 145 * ANGLE_STEPS;

   // Working width of the CORDIC and multiplier operands (Q2.30 plus headroom)
   localparam int TW = 34;
   localparam int PW = 2 * TW;

   typedef logic signed [31:0]   coord_type;
   typedef logic [14:0]          angle_type;
   typedef logic signed [TW-1:0] tw_type;
   typedef logic signed [PW-1:0] prod_type;

   typedef enum logic {
      REQ_SWING = 1'b0,
      REQ_SET   = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_FOCUS_X = 2'd0,
      CSR_FOCUS_Y = 2'd1,
      CSR_FOCUS_Z = 2'd2
   } csr_idx_type;

   // Handshake between the sequencer and one of its iterative units
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // atan(2^-i) in Q2.30
   function automatic tw_type atan_q30(input logic [4:0] i);
      tw_type v;
      case (i)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         5'd24: v = 34'sd64;
         5'd25: v = 34'sd32;
         5'd26: v = 34'sd16;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Wrap a sum of angle and delta into [0, ANGLE_FULL)
   function automatic angle_type wrap_angle(input logic signed [17:0] s);
      logic signed [17:0] t;
      t = s;
      if (t < 0) t = t + 18'(ANGLE_FULL);
      if (t < 0) t = t + 18'(ANGLE_FULL);
      if (t >= 18'(ANGLE_FULL)) t = t - 18'(ANGLE_FULL);
      if (t >= 18'(ANGLE_FULL)) t = t - 18'(ANGLE_FULL);
      return t[14:0];
   endfunction

   // Round a product at 2^30, ties upward
   function automatic logic signed [37:0] rnd30(input prod_type p);
      prod_type t;
      t = p + PW'(64'sd536870912);
      return t[PW-1:30];
   endfunction

   // Saturate to the signed 32-bit range
   function automatic coord_type sat32(input logic signed [38:0] v);
      coord_type r;
      if (v > 39'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -39'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

// ----- sv/ocs_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on ocs_pkg.
module ocs_mul (
   input  logic            clock,
   input  ocs_pkg::tw_type op_a,
   input  ocs_pkg::tw_type op_b,
   output ocs_pkg::prod_type prod
);
   import ocs_pkg::*;

   prod_type prod_ff;

   // one product per cycle, available the cycle after issue
   always_ff @(posedge clock) begin
      prod_ff <= PW'(op_a) * PW'(op_b);
   end

   assign prod = prod_ff;

endmodule

// ----- sv/ocs_root.sv -----
// Bit-serial integer square root: one result bit per cycle, 34 result bits.
// Depends on ocs_pkg.
module ocs_root (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [67:0]   radicand,
   output ocs_pkg::unit_stat_type stat,
   output logic [33:0]   root
);
   import ocs_pkg::*;

   logic [67:0] sh_ff;
   logic [35:0] rem_ff;
   logic [33:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [37:0] rem_w;
   logic [37:0] trial;
   logic        ge;
   logic [37:0] rem_in;

   // one restoring step: bring down two bits, try 4*root+1
   always_comb begin
      rem_w  = {rem_ff, sh_ff[67:66]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = (rem_w >= trial);
      rem_in = ge ? (rem_w - trial) : rem_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd33;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff   <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         sh_ff   <= {sh_ff[65:0], 2'b00};
         rem_ff  <= rem_in[35:0];
         root_ff <= {root_ff[32:0], ge};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

// ----- sv/ocs_cordic.sv -----
// Rotation CORDIC for cos and sin in Q2.30, one micro-rotation per cycle,
// with quadrant folding around it. Depends on ocs_pkg.
module ocs_cordic #(
   parameter int ITERS = ocs_pkg::CORDIC_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ocs_pkg::angle_type angle,
   output ocs_pkg::unit_stat_type stat,
   output ocs_pkg::tw_type    cos_q,
   output ocs_pkg::tw_type    sin_q
);
   import ocs_pkg::*;

   localparam int IW = (ITERS > 1) ? $clog2(ITERS) : 1;

   tw_type      x_ff, y_ff, z_ff;
   logic [1:0]  q_ff;
   logic [IW-1:0] i_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [1:0]  q_w;
   logic [14:0] r_w;
   logic [37:0] zp;
   tw_type      xs, ys, at;

   // quadrant and residue, then residue to Q2.30 radians
   always_comb begin
      if (angle >= 15'(3 * ANGLE_QUARTER)) begin
         q_w = 2'd3;
         r_w = angle - 15'(3 * ANGLE_QUARTER);
      end else if (angle >= 15'(2 * ANGLE_QUARTER)) begin
         q_w = 2'd2;
         r_w = angle - 15'(2 * ANGLE_QUARTER);
      end else if (angle >= 15'(ANGLE_QUARTER)) begin
         q_w = 2'd1;
         r_w = angle - 15'(ANGLE_QUARTER);
      end else begin
         q_w = 2'd0;
         r_w = angle;
      end
      zp = 38'(r_w) * 38'(ONE_DEG_Q30) + 38'(ANGLE_STEPS / 2);
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = atan_q30(5'(i_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            i_ff    <= '0;
         end else if (busy_ff) begin
            i_ff <= i_ff + IW'(1);
            if (i_ff == IW'(ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // micro-rotation datapath
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= TW'(CORDIC_GAIN_Q30);
         y_ff <= '0;
         z_ff <= $signed({2'b00, zp[37:6]});
         q_ff <= q_w;
      end else if (busy_ff) begin
         if (!z_ff[TW-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   // unfold the quadrant
   always_comb begin
      case (q_ff)
         2'd0: begin cos_q = x_ff;  sin_q = y_ff;  end
         2'd1: begin cos_q = -y_ff; sin_q = x_ff;  end
         2'd2: begin cos_q = -x_ff; sin_q = -y_ff; end
         default: begin cos_q = y_ff; sin_q = -x_ff; end
      endcase
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- sv/orbit_camera_swing_top.sv -----
// Orbit camera swing block: top level with the request sequencer, state,
// focus registers and result register. Depends on ocs_pkg, ocs_mul,
// ocs_root and ocs_cordic.
//
// Usage:
//   req_ channel: one transaction per request. req_tuser is the request kind
//   (swing or set position); req_tdata carries the angle deltas, move
//   distance and new position. req_tready is high only while the block is
//   idle, so a new request can be taken in the cycle after the previous result is registered.
//   rsp_ channel: one transaction per request with position, radius, both
//   angles and the up flag, held in an output register until taken.
//   csr_ channel: focus point writes, always ready, index 0..2; index 3 is
//   dropped. Write only while no request is in flight.
//   Sequence: a set request runs the 3 squares through the shared multiplier
//   and then the 34 square-root steps; a swing goes on to two passes through
//   the one CORDIC unit and five products on the one multiplier.
//   Reset: camera at (2, 2, 2), angles 315 and 145 degrees, focus at 0.
//   A stalled receiver holds the result; a finished next request then waits
//   in its last state until the output register is free.
module orbit_camera_swing_top #(
   parameter int CORDIC_ITERATIONS = ocs_pkg::CORDIC_ITER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // delta_h[15:0], delta_v[31:16], radius_step[63:32], new_x[95:64],
   // new_y[127:96], new_z[159:128]
   input  logic [159:0] req_tdata,
   // req_type[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64], radius[127:96],
   // angle_h[142:128], angle_v[157:143], up_positive[158], zero[159]
   output logic [159:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import ocs_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQ     = 7'b0000010,
      ST_ROOT   = 7'b0000100,
      ST_TRIG_H = 7'b0001000,
      ST_TRIG_V = 7'b0010000,
      ST_MUL    = 7'b0100000,
      ST_FIN    = 7'b1000000
   } state_type;

   state_type    state_ff;
   logic [2:0]   step_ff;
   coord_type    focus_x_ff, focus_y_ff, focus_z_ff;
   coord_type    cam_x_ff, cam_y_ff, cam_z_ff;
   angle_type    horiz_ff, vert_ff, nh_ff, nv_ff;
   req_kind_type kind_ff;
   coord_type    move_ff;
   logic [65:0]  acc_ff;
   logic [31:0]  rad_ff;
   tw_type       ch_ff, sh_ff, cv_ff, sv_ff, tx_ff, tz_ff;
   logic         rsp_valid_ff;
   logic [159:0] rsp_data_ff;

   logic               req_acc;
   logic signed [32:0] dx, dy, dz;
   tw_type             op_a, op_b;
   prod_type           prod;
   logic [65:0]        acc_sum;
   logic signed [37:0] prod_rnd;
   logic               root_start, trig_start;
   unit_stat_type      root_stat, trig_stat;
   logic [33:0]        root;
   angle_type          trig_angle;
   tw_type             cos_q, sin_q;
   logic signed [35:0] dsum;
   logic [31:0]        rad_swing, rad_set;
   tw_type             rad_op;
   logic               up;
   logic               rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   // offset from focus
   assign dx = 33'(cam_x_ff) - 33'(focus_x_ff);
   assign dy = 33'(cam_y_ff) - 33'(focus_y_ff);
   assign dz = 33'(cam_z_ff) - 33'(focus_z_ff);

   assign acc_sum  = acc_ff + 66'(prod[63:0]);
   assign prod_rnd = rnd30(prod);
   assign rad_op   = $signed({2'b00, rad_ff});

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (state_ff == ST_SQ) begin
         case (step_ff)
            3'd0: begin op_a = TW'(dx); op_b = TW'(dx); end
            3'd1: begin op_a = TW'(dy); op_b = TW'(dy); end
            3'd2: begin op_a = TW'(dz); op_b = TW'(dz); end
            default: ;
         endcase
      end else if (state_ff == ST_MUL) begin
         case (step_ff)
            3'd0: begin op_a = cv_ff;  op_b = sh_ff; end
            3'd1: begin op_a = cv_ff;  op_b = ch_ff; end
            3'd2: begin op_a = rad_op; op_b = tx_ff; end
            3'd3: begin op_a = rad_op; op_b = sv_ff; end
            3'd4: begin op_a = rad_op; op_b = tz_ff; end
            default: ;
         endcase
      end
   end

   // radius after the move, clamped; radius of a set request, saturated
   always_comb begin
      dsum = 36'($signed({2'b00, root})) + 36'(move_ff);
      if (dsum < 36'(MIN_RADIUS))
         rad_swing = 32'(MIN_RADIUS);
      else if (dsum > 36'sh0FFFFFFFF)
         rad_swing = 32'hFFFFFFFF;
      else
         rad_swing = dsum[31:0];
      rad_set = (root > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : root[31:0];
   end

   assign root_start = (state_ff == ST_SQ) && (step_ff == 3'd3);
   assign trig_start = ((state_ff == ST_ROOT) && root_stat.done && (kind_ff == REQ_SWING))
                    || ((state_ff == ST_TRIG_H) && trig_stat.done);
   assign trig_angle = (state_ff == ST_ROOT) ? nh_ff : nv_ff;

   assign up = (vert_ff > 15'(ANGLE_QUARTER)) && (vert_ff < 15'(3 * ANGLE_QUARTER));

   ocs_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   ocs_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({2'b00, acc_sum}),
      .stat     (root_stat),
      .root     (root)
   );

   ocs_cordic #(
      .ITERS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (trig_start),
      .angle (trig_angle),
      .stat  (trig_stat),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   // focus registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focus_x_ff <= '0;
         focus_y_ff <= '0;
         focus_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_FOCUS_X: focus_x_ff <= csr_data;
            CSR_FOCUS_Y: focus_y_ff <= csr_data;
            CSR_FOCUS_Z: focus_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer and camera state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cam_x_ff     <= 32'(CAM_RESET);
         cam_y_ff     <= 32'(CAM_RESET);
         cam_z_ff     <= 32'(CAM_RESET);
         horiz_ff     <= 15'(HORIZ_RESET);
         vert_ff      <= 15'(VERT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register: load a finished result, or drop a taken one
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_kind_type'(req_tuser[0]) == REQ_SET) begin
                     cam_x_ff <= req_tdata[95:64];
                     cam_y_ff <= req_tdata[127:96];
                     cam_z_ff <= req_tdata[159:128];
                  end
                  step_ff  <= '0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd3) state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (root_stat.done) begin
                  state_ff <= (kind_ff == REQ_SET) ? ST_FIN : ST_TRIG_H;
               end
            end
            ST_TRIG_H: begin
               if (trig_stat.done) state_ff <= ST_TRIG_V;
            end
            ST_TRIG_V: begin
               if (trig_stat.done) begin
                  step_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + 3'd1;
               case (step_ff)
                  3'd3: cam_x_ff <= sat32(39'(focus_x_ff) + 39'(prod_rnd));
                  3'd4: cam_y_ff <= sat32(39'(focus_y_ff) + 39'(prod_rnd));
                  3'd5: begin
                     cam_z_ff <= sat32(39'(focus_z_ff) - 39'(prod_rnd));
                     horiz_ff <= nh_ff;
                     vert_ff  <= nv_ff;
                     state_ff <= ST_FIN;
                  end
                  default: ;
               endcase
            end
            ST_FIN: begin
               if (rsp_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // request payload and intermediate results
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff <= req_kind_type'(req_tuser[0]);
         move_ff <= req_tdata[63:32];
         nh_ff   <= wrap_angle(18'($signed({1'b0, horiz_ff}))
                               + 18'($signed(req_tdata[15:0])));
         nv_ff   <= wrap_angle(18'($signed({1'b0, vert_ff}))
                               + 18'($signed(req_tdata[31:16])));
      end
      if (state_ff == ST_SQ) begin
         if (step_ff == 3'd1)      acc_ff <= 66'(prod[63:0]);
         else if (step_ff >= 3'd2) acc_ff <= acc_sum;
      end
      if (state_ff == ST_ROOT && root_stat.done) begin
         rad_ff <= (kind_ff == REQ_SET) ? rad_set : rad_swing;
      end
      if (state_ff == ST_TRIG_H && trig_stat.done) begin
         ch_ff <= cos_q;
         sh_ff <= sin_q;
      end
      if (state_ff == ST_TRIG_V && trig_stat.done) begin
         cv_ff <= cos_q;
         sv_ff <= sin_q;
      end
      if (state_ff == ST_MUL && step_ff == 3'd1) tx_ff <= TW'(prod_rnd);
      if (state_ff == ST_MUL && step_ff == 3'd2) tz_ff <= TW'(prod_rnd);
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, up, vert_ff, horiz_ff, rad_ff,
                         cam_z_ff, cam_y_ff, cam_x_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a new request is never taken in the cycle after one was taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request accepted while busy");

   // stored angles stay wrapped
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (horiz_ff < 15'(ANGLE_FULL)) && (vert_ff < 15'(ANGLE_FULL)))
      else $error("stored angle out of range");

   // the units only run while the sequencer waits on them
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (root_stat.busy || trig_stat.busy) |-> (state_ff != ST_IDLE))
      else $error("unit busy while idle");

   // a swing result never reports a radius below the minimum
   a_min_radius: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && kind_ff == REQ_SWING) |-> (rad_ff >= 32'(MIN_RADIUS)))
      else $error("swing radius below minimum");
`endif

endmodule
